// ===== rtl/core/tbft_pkg.sv =====
// ----------------------------------------------------------------------------
// tbft_pkg
// Types, opcodes and the reconcile/free-buffer helpers of the triple-buffer
// flip tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package tbft_pkg;

    localparam logic [2:0] OP_STATUS   = 3'd0;
    localparam logic [2:0] OP_CPU_FLIP = 3'd1;
    localparam logic [2:0] OP_GPU_ACK  = 3'd2;
    localparam logic [2:0] OP_VBLANK   = 3'd3;
    localparam logic [2:0] OP_VSYNC    = 3'd4;

    // display index that carries no information
    localparam logic [1:0] IDX_NONE = 2'd3;

    typedef struct packed {
        logic [2:0]  opcode;
        logic        sampled_pending;
        logic [1:0]  sampled_display;
        logic        flipped_valid;
        logic [1:0]  flipped_index;
        logic        fence_done;
        logic        irq_pending;
        logic [63:0] timestamp;
    } t_tbft_req;

    typedef struct packed {
        logic [1:0]  draw_index;
        logic        swap_request;
        logic [1:0]  swap_index;
        logic [1:0]  display_index;
        logic        ready_valid;
        logic [1:0]  ready_index;
        logic [31:0] vblank_total;
        logic [31:0] present_total;
        logic [1:0]  last_presented;
        logic [63:0] present_time;
    } t_tbft_res;

    typedef struct packed {
        logic [1:0]  shown;
        logic [1:0]  drawing;
        logic [1:0]  queued;
        logic        queued_valid;
        logic        kick_seen;
        logic        uncounted;
        logic [31:0] vblank_cnt;
        logic [31:0] present_cnt;
        logic [1:0]  presented;
        logic [63:0] vblank_time;
        logic [63:0] present_stamp;
    } t_tbft_state;

    localparam t_tbft_state STATE_RESET = '{
        shown:         2'd0,
        drawing:       2'd1,
        queued:        2'd0,
        queued_valid:  1'b0,
        kick_seen:     1'b0,
        uncounted:     1'b0,
        vblank_cnt:    32'd0,
        present_cnt:   32'd0,
        presented:     2'd0,
        vblank_time:   64'd0,
        present_stamp: 64'd0
    };

    function automatic t_tbft_state tbft_reconcile(
        input t_tbft_state s,
        input logic        pend,
        input logic [1:0]  disp,
        input logic        irq,
        input logic [63:0] now
    );
        t_tbft_state r;
        r = s;
        if (disp != IDX_NONE) begin
            r.shown = disp;
        end
        if (pend) begin
            r.kick_seen = 1'b1;
        end
        if (r.queued_valid && !pend && (r.queued == r.shown || r.kick_seen) &&
            r.uncounted) begin
            r.present_cnt = r.present_cnt + 32'd1;
            r.presented   = r.queued;
            if (irq) begin
                r.present_stamp = now;
            end else if (r.vblank_time != 64'd0) begin
                r.present_stamp = r.vblank_time;
            end else begin
                r.present_stamp = now;
            end
            r.uncounted = 1'b0;
        end
        if (r.queued_valid && r.queued == r.shown) begin
            r.queued_valid = 1'b0;
            r.kick_seen    = 1'b0;
        end else if (r.queued_valid && r.kick_seen && !pend) begin
            r.shown        = r.queued;
            r.queued_valid = 1'b0;
            r.kick_seen    = 1'b0;
        end
        return r;
    endfunction

    // lowest buffer that is neither shown nor queued
    function automatic logic [1:0] tbft_free_buffer(input t_tbft_state s);
        logic [1:0] idx;
        logic       found;
        idx   = s.drawing;
        found = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (!found && 2'(i) != s.shown && !(s.queued_valid && 2'(i) == s.queued)) begin
                idx   = 2'(i);
                found = 1'b1;
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tbft_step.sv =====
// ----------------------------------------------------------------------------
// tbft_step
// Next-state and result logic for one request, from the current buffer
// roles and the request's single status sample.
// ----------------------------------------------------------------------------
`default_nettype none

module tbft_step
    import tbft_pkg::*;
(
    input  var t_tbft_state i_state,
    input  var t_tbft_req   i_req,
    output t_tbft_state     o_state,
    output t_tbft_res       o_res
);

    t_tbft_state s;
    logic        sreq;
    logic [1:0]  sidx;
    logic [1:0]  prev_draw;

    always_comb begin
        s         = i_state;
        sreq      = 1'b0;
        sidx      = 2'd0;
        prev_draw = 2'd0;
        unique case (i_req.opcode)
            OP_CPU_FLIP: begin
                s = tbft_reconcile(s, i_req.sampled_pending, i_req.sampled_display,
                                   i_req.irq_pending, i_req.timestamp);
                sreq        = 1'b1;
                sidx        = s.drawing;
                s.kick_seen = 1'b1;
                prev_draw   = s.drawing;
                if (s.queued_valid) begin
                    s.drawing = s.queued;
                end else begin
                    s.drawing = 2'd3 - s.shown - prev_draw;
                end
                s.queued       = prev_draw;
                s.queued_valid = 1'b1;
                s.uncounted    = 1'b1;
            end
            OP_GPU_ACK: begin
                s = tbft_reconcile(s, i_req.sampled_pending, i_req.sampled_display,
                                   i_req.irq_pending, i_req.timestamp);
                if (i_req.flipped_valid) begin
                    s = tbft_reconcile(s, i_req.sampled_pending, i_req.sampled_display,
                                       i_req.irq_pending, i_req.timestamp);
                    if (!i_req.fence_done) begin
                        sreq = 1'b1;
                        sidx = i_req.flipped_index;
                    end
                    s.queued       = i_req.flipped_index;
                    s.queued_valid = 1'b1;
                    s.uncounted    = 1'b1;
                    s.kick_seen    = 1'b1;
                    s = tbft_reconcile(s, i_req.sampled_pending, i_req.sampled_display,
                                       i_req.irq_pending, i_req.timestamp);
                    s.drawing = tbft_free_buffer(s);
                end
            end
            OP_VBLANK: begin
                s.vblank_cnt  = s.vblank_cnt + 32'd1;
                s.vblank_time = i_req.timestamp;
                s = tbft_reconcile(s, i_req.sampled_pending, i_req.sampled_display,
                                   i_req.irq_pending, i_req.timestamp);
            end
            OP_VSYNC: begin
                s = tbft_reconcile(s, i_req.sampled_pending, i_req.sampled_display,
                                   i_req.irq_pending, i_req.timestamp);
                sreq = 1'b1;
                sidx = s.shown;
            end
            default: begin
                s = tbft_reconcile(s, i_req.sampled_pending, i_req.sampled_display,
                                   i_req.irq_pending, i_req.timestamp);
            end
        endcase
    end

    assign o_state = s;

    always_comb begin
        o_res.draw_index     = s.drawing;
        o_res.swap_request   = sreq;
        o_res.swap_index     = sidx;
        o_res.display_index  = s.shown;
        o_res.ready_valid    = s.queued_valid;
        o_res.ready_index    = s.queued_valid ? s.queued : 2'd0;
        o_res.vblank_total   = s.vblank_cnt;
        o_res.present_total  = s.present_cnt;
        o_res.last_presented = s.presented;
        o_res.present_time   = s.present_stamp;
    end

endmodule

`default_nettype wire

// ===== rtl/core/tbft_skid.sv =====
// ----------------------------------------------------------------------------
// tbft_skid
// Result register with one skid entry; keeps results in order while the
// receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tbft_skid
    import tbft_pkg::*;
(
    input  var logic      i_clk,
    input  var logic      i_rst_n,
    input  var logic      i_push,
    input  var t_tbft_res i_data,
    output logic          o_space,
    output logic          o_valid,
    input  var logic      i_ready,
    output t_tbft_res     o_data
);

    logic      r_out_valid;
    logic      r_skid_valid;
    t_tbft_res r_out;
    t_tbft_res r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (i_push) begin
                r_out <= i_data;
            end
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

    assign o_space = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

// ===== rtl/core/triple_buffer_flip_tracker.sv =====
// ----------------------------------------------------------------------------
// triple_buffer_flip_tracker
// Tracks the shown, drawn and queued roles of three frame buffers.
//
// Request channel (i_req_valid / o_req_ready / i_req): one event per request,
// carrying the opcode and a single sampled swap status used for every
// reconcile of that request.
// Result channel (o_res_valid / i_res_ready / o_res): exactly one result per
// request, in request order.
// Throughput: one request per cycle while o_req_ready is high; the roles
// and counters update in the same edge that takes the request, so the next
// request sees them at once. Each result is registered on its way out.
// Stall: a result register plus one skid entry; o_req_ready drops only when
// both are full and recovers as soon as the receiver takes a result.
// Reset: drawing buffer 1, all other roles, counters and stamps zero, no
// result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module triple_buffer_flip_tracker
    import tbft_pkg::*;
(
    input  var logic      i_clk,
    input  var logic      i_rst_n,
    input  var logic      i_req_valid,
    output logic          o_req_ready,
    input  var t_tbft_req i_req,
    output logic          o_res_valid,
    input  var logic      i_res_ready,
    output t_tbft_res     o_res
);

    t_tbft_state r_state;
    t_tbft_state n_state;
    t_tbft_res   step_res;
    logic        push;

    assign push = i_req_valid && o_req_ready;

    tbft_step u_step (
        .i_state (r_state),
        .i_req   (i_req),
        .o_state (n_state),
        .o_res   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (push) begin
            r_state <= n_state;
        end
    end

    tbft_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (step_res),
        .o_space (o_req_ready),
        .o_valid (o_res_valid),
        .i_ready (i_res_ready),
        .o_data  (o_res)
    );

endmodule

`default_nettype wire

// ===== tb/sv/triple_buffer_flip_tracker_checker.sv =====
// ----------------------------------------------------------------------------
// triple_buffer_flip_tracker_checker
// Watches the request and result channels of the flip tracker, keeps its own
// copy of the buffer roles, counters and stamps, predicts one result for every
// accepted request and compares each accepted result field by field.
// ----------------------------------------------------------------------------
module triple_buffer_flip_tracker_checker
    import tbft_pkg::*;
(
    input  var logic      i_clk,
    input  var logic      i_rst_n,
    input  var logic      i_req_valid,
    input  var logic      i_req_ready,
    input  var t_tbft_req i_req,
    input  var logic      i_res_valid,
    input  var logic      i_res_ready,
    input  var t_tbft_res i_res,
    output int            o_fail_count,
    output int            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [1:0]  scan_buf;
    logic [1:0]  draw_buf;
    logic [1:0]  queue_buf;
    logic        queue_full;
    logic        kicked;
    logic        present_open;
    logic [31:0] vblank_tally;
    logic [31:0] present_tally;
    logic [1:0]  last_present_buf;
    logic [63:0] vblank_stamp;
    logic [63:0] present_stamp;

    t_tbft_res   result_fifo[$];
    int          fails = 0;

    function automatic void clear_roles();
        scan_buf         = 2'd0;
        draw_buf         = 2'd1;
        queue_buf        = 2'd0;
        queue_full       = 1'b0;
        kicked           = 1'b0;
        present_open     = 1'b0;
        vblank_tally     = 32'd0;
        present_tally    = 32'd0;
        last_present_buf = 2'd0;
        vblank_stamp     = 64'd0;
        present_stamp    = 64'd0;
    endfunction

    function automatic void log_present(input logic irq, input logic [63:0] now);
        if (present_open) begin
            present_tally    = present_tally + 32'd1;
            last_present_buf = queue_buf;
            if (irq) begin
                present_stamp = now;
            end else if (vblank_stamp != 64'd0) begin
                present_stamp = vblank_stamp;
            end else begin
                present_stamp = now;
            end
            present_open = 1'b0;
        end
    endfunction

    // fold the sampled swap status into the roles
    function automatic void sync_status(input logic pend, input logic [1:0] disp,
                                        input logic irq, input logic [63:0] now);
        if (disp != IDX_NONE) begin
            scan_buf = disp;
        end
        if (pend) begin
            kicked = 1'b1;
        end
        if (queue_full && !pend && (queue_buf == scan_buf || kicked)) begin
            log_present(irq, now);
        end
        if (queue_full && queue_buf == scan_buf) begin
            queue_full = 1'b0;
            kicked     = 1'b0;
        end else if (queue_full && kicked && !pend) begin
            scan_buf   = queue_buf;
            queue_full = 1'b0;
            kicked     = 1'b0;
        end
    endfunction

    function automatic void enqueue(input logic [1:0] idx);
        queue_buf    = idx;
        queue_full   = 1'b1;
        present_open = 1'b1;
    endfunction

    function automatic logic [1:0] lowest_free();
        for (int i = 0; i < 3; i++) begin
            if (2'(i) != scan_buf && !(queue_full && 2'(i) == queue_buf)) begin
                return 2'(i);
            end
        end
        return draw_buf;
    endfunction

    function automatic t_tbft_res apply_request(input t_tbft_req r);
        t_tbft_res  e;
        logic [1:0] prev;
        e = '0;
        case (r.opcode)
            OP_CPU_FLIP: begin
                sync_status(r.sampled_pending, r.sampled_display, r.irq_pending, r.timestamp);
                e.swap_request = 1'b1;
                e.swap_index   = draw_buf;
                kicked         = 1'b1;
                prev           = draw_buf;
                draw_buf       = queue_full ? queue_buf : 2'(2'd3 - scan_buf - prev);
                enqueue(prev);
            end
            OP_GPU_ACK: begin
                sync_status(r.sampled_pending, r.sampled_display, r.irq_pending, r.timestamp);
                if (r.flipped_valid) begin
                    sync_status(r.sampled_pending, r.sampled_display, r.irq_pending,
                                r.timestamp);
                    if (!r.fence_done) begin
                        e.swap_request = 1'b1;
                        e.swap_index   = r.flipped_index;
                    end
                    enqueue(r.flipped_index);
                    kicked = 1'b1;
                    sync_status(r.sampled_pending, r.sampled_display, r.irq_pending,
                                r.timestamp);
                    draw_buf = lowest_free();
                end
            end
            OP_VBLANK: begin
                vblank_tally = vblank_tally + 32'd1;
                vblank_stamp = r.timestamp;
                sync_status(r.sampled_pending, r.sampled_display, r.irq_pending, r.timestamp);
            end
            OP_VSYNC: begin
                sync_status(r.sampled_pending, r.sampled_display, r.irq_pending, r.timestamp);
                e.swap_request = 1'b1;
                e.swap_index   = scan_buf;
            end
            default: begin
                sync_status(r.sampled_pending, r.sampled_display, r.irq_pending, r.timestamp);
            end
        endcase
        e.draw_index     = draw_buf;
        e.display_index  = scan_buf;
        e.ready_valid    = queue_full;
        e.ready_index    = queue_full ? queue_buf : 2'd0;
        e.vblank_total   = vblank_tally;
        e.present_total  = present_tally;
        e.last_presented = last_present_buf;
        e.present_time   = present_stamp;
        return e;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: %s got %0h expected %0h", $time, what, got, want);
        fails++;
    endtask

    task automatic compare_result(input t_tbft_res got, input t_tbft_res want);
        if (got.draw_index !== want.draw_index)
            report_mismatch("draw_index", 64'(got.draw_index), 64'(want.draw_index));
        if (got.swap_request !== want.swap_request)
            report_mismatch("swap_request", 64'(got.swap_request), 64'(want.swap_request));
        if (got.swap_index !== want.swap_index)
            report_mismatch("swap_index", 64'(got.swap_index), 64'(want.swap_index));
        if (got.display_index !== want.display_index)
            report_mismatch("display_index", 64'(got.display_index),
                            64'(want.display_index));
        if (got.ready_valid !== want.ready_valid)
            report_mismatch("ready_valid", 64'(got.ready_valid), 64'(want.ready_valid));
        if (got.ready_index !== want.ready_index)
            report_mismatch("ready_index", 64'(got.ready_index), 64'(want.ready_index));
        if (got.vblank_total !== want.vblank_total)
            report_mismatch("vblank_total", 64'(got.vblank_total), 64'(want.vblank_total));
        if (got.present_total !== want.present_total)
            report_mismatch("present_total", 64'(got.present_total),
                            64'(want.present_total));
        if (got.last_presented !== want.last_presented)
            report_mismatch("last_presented", 64'(got.last_presented),
                            64'(want.last_presented));
        if (got.present_time !== want.present_time)
            report_mismatch("present_time", got.present_time, want.present_time);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_roles();
            result_fifo.delete();
        end else begin
            // a result at this edge belongs to an earlier request
            if (i_res_valid && i_res_ready) begin
                if (result_fifo.size() == 0) begin
                    report_mismatch("result with no request outstanding",
                                    64'(i_res.draw_index), 64'd0);
                end else begin
                    compare_result(i_res, result_fifo.pop_front());
                end
            end
            if (i_req_valid && i_req_ready) begin
                result_fifo.push_back(apply_request(i_req));
            end
        end
        o_fail_count <= fails;
        o_pending    <= result_fifo.size();
    end

endmodule

// ===== tb/sv/triple_buffer_flip_tracker_tb.sv =====
// ----------------------------------------------------------------------------
// triple_buffer_flip_tracker_tb
// Drives the flip tracker with a short directed sequence and then with random
// requests shaped like a display pipeline (flip, pending swap, vblank landing
// the swap) mixed with noise, under several sender and receiver idle phases.
// Checking is done by the checker instance beside the block.
// ----------------------------------------------------------------------------
module triple_buffer_flip_tracker_tb
    import tbft_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_REQS  = 132;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_req_valid = 1'b0;
    logic      i_res_ready = 1'b0;
    t_tbft_req i_req       = '0;
    logic      o_req_ready;
    logic      o_res_valid;
    t_tbft_res o_res;

    int fail_count;
    int pending;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;

    // crude display hardware: swaps seen on the result side land at a vblank
    int          swap_count  = 0;
    logic [1:0]  swap_target = 2'd0;
    int          swaps_landed = 0;
    logic [1:0]  hw_scan     = 2'd0;
    logic [63:0] ts_now      = 64'd1000;

    always #2 i_clk = ~i_clk;

    triple_buffer_flip_tracker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (o_res)
    );

    triple_buffer_flip_tracker_checker flip_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req_valid),
        .i_req_ready  (o_req_ready),
        .i_req        (i_req),
        .i_res_valid  (o_res_valid),
        .i_res_ready  (i_res_ready),
        .i_res        (o_res),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("triple_buffer_flip_tracker_tb failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_res_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (o_res_valid && i_res_ready && o_res.swap_request) begin
            swap_count  <= swap_count + 1;
            swap_target <= o_res.swap_index;
        end
    end

    task automatic send(input t_tbft_req r);
        while ($urandom_range(99) < send_idle_pct) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= r;
        @(posedge i_clk);
        while (!o_req_ready) @(posedge i_clk);
    endtask

    task automatic send_fields(input logic [2:0] op, input logic pend, input logic [1:0] disp,
                               input logic fval, input logic [1:0] fidx, input logic fence,
                               input logic irq, input logic [63:0] ts);
        t_tbft_req r;
        r.opcode          = op;
        r.sampled_pending = pend;
        r.sampled_display = disp;
        r.flipped_valid   = fval;
        r.flipped_index   = fidx;
        r.fence_done      = fence;
        r.irq_pending     = irq;
        r.timestamp       = ts;
        send(r);
    endtask

    task automatic wait_drained();
        i_req_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic send_random();
        t_tbft_req r;
        int        pick;
        pick = $urandom_range(99);
        if (pick < 25)      r.opcode = OP_STATUS;
        else if (pick < 45) r.opcode = OP_CPU_FLIP;
        else if (pick < 65) r.opcode = OP_GPU_ACK;
        else if (pick < 85) r.opcode = OP_VBLANK;
        else if (pick < 95) r.opcode = OP_VSYNC;
        else                r.opcode = 3'($urandom_range(7, 5));
        if ($urandom_range(9) < 8) begin
            r.sampled_pending = (swap_count != swaps_landed);
            r.sampled_display = hw_scan;
            if (r.opcode == OP_VBLANK && r.sampled_pending) begin
                r.sampled_pending = 1'b0;
                r.sampled_display = swap_target;
                hw_scan           = swap_target;
                swaps_landed      = swap_count;
            end
        end else begin
            r.sampled_pending = 1'($urandom_range(1));
            r.sampled_display = 2'($urandom_range(3));
        end
        r.flipped_valid = ($urandom_range(4) != 0);
        r.flipped_index = 2'($urandom_range(3));
        r.fence_done    = ($urandom_range(9) < 7);
        r.irq_pending   = 1'($urandom_range(1));
        pick = $urandom_range(99);
        if (pick < 5) begin
            r.timestamp = 64'd0;
        end else if (pick < 10) begin
            r.timestamp = {$urandom, $urandom};
        end else begin
            ts_now      = ts_now + 64'($urandom_range(5000, 1));
            r.timestamp = ts_now;
        end
        send(r);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_fields(OP_STATUS, 1'b0, IDX_NONE, 1'b0, 2'd0, 1'b0, 1'b0, 64'd0);
        send_fields(OP_STATUS, 1'b1, 2'd0, 1'b1, 2'd3, 1'b1, 1'b1, 64'd5);
        send_fields(OP_CPU_FLIP, 1'b0, IDX_NONE, 1'b0, 2'd0, 1'b0, 1'b0, 64'd10);
        send_fields(OP_VBLANK, 1'b0, 2'd1, 1'b0, 2'd0, 1'b0, 1'b0, 64'd0);
        send_fields(OP_VBLANK, 1'b1, IDX_NONE, 1'b0, 2'd0, 1'b0, 1'b0,
                    64'hFFFF_FFFF_FFFF_FFFF);
        send_fields(OP_CPU_FLIP, 1'b1, IDX_NONE, 1'b0, 2'd0, 1'b0, 1'b1, 64'd20);
        send_fields(OP_STATUS, 1'b0, IDX_NONE, 1'b0, 2'd0, 1'b0, 1'b0, 64'd30);
        send_fields(OP_GPU_ACK, 1'b0, IDX_NONE, 1'b0, 2'd3, 1'b0, 1'b0, 64'd40);
        send_fields(OP_GPU_ACK, 1'b0, IDX_NONE, 1'b1, 2'd3, 1'b0, 1'b0, 64'd50);
        send_fields(OP_GPU_ACK, 1'b1, 2'd0, 1'b1, 2'd2, 1'b1, 1'b1, 64'd60);
        send_fields(OP_VSYNC, 1'b0, 2'd2, 1'b0, 2'd0, 1'b0, 1'b0, 64'd70);
        send_fields(3'd5, 1'b1, 2'd1, 1'b1, 2'd1, 1'b1, 1'b1, 64'd80);
        send_fields(3'd6, 1'b0, 2'd3, 1'b0, 2'd2, 1'b0, 1'b0, 64'd90);
        send_fields(3'd7, 1'b0, 2'd0, 1'b1, 2'd3, 1'b1, 1'b0, 64'd100);
        send_fields(OP_CPU_FLIP, 1'b0, 2'd2, 1'b0, 2'd0, 1'b0, 1'b0, 64'd110);
        send_fields(OP_CPU_FLIP, 1'b1, 2'd0, 1'b0, 2'd0, 1'b0, 1'b1, 64'd120);
        send_fields(OP_VBLANK, 1'b0, IDX_NONE, 1'b0, 2'd0, 1'b0, 1'b1, 64'd130);
        send_fields(OP_CPU_FLIP, 1'b0, 2'd1, 1'b0, 2'd0, 1'b0, 1'b0, 64'd140);
        send_fields(OP_CPU_FLIP, 1'b0, 2'd2, 1'b0, 2'd0, 1'b0, 1'b0, 64'd150);
        send_fields(OP_GPU_ACK, 1'b0, 2'd1, 1'b1, 2'd0, 1'b0, 1'b0, 64'd160);
        send_fields(OP_VSYNC, 1'b1, IDX_NONE, 1'b1, 2'd1, 1'b1, 1'b1,
                    64'hFFFF_FFFF_FFFF_FFFF);
        send_fields(OP_VBLANK, 1'b0, 2'd2, 1'b0, 2'd0, 1'b0, 1'b0, 64'd170);
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 59; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 59; end
                default: begin send_idle_pct = 13; stall_pct = 13; end
            endcase
            for (int n = 0; n < PHASE_REQS; n++) begin
                send_random();
            end
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("triple_buffer_flip_tracker_tb passed");
        end else begin
            $display("triple_buffer_flip_tracker_tb failed");
        end
        $finish;
    end

endmodule
